[hdl/char_lcd_write_sequencer_assert.svh]
// Assertion macros for the character LCD write sequencer.
`ifndef CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LCDWS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LCDWS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/lcdws_pkg.sv]
// Shared types, codes and init tables for the character LCD write sequencer.
`timescale 1ns / 1ps

package lcdws_pkg;

	// request kinds
	localparam logic [2:0] ACT_DATA   = 3'd0;
	localparam logic [2:0] ACT_CMD    = 3'd1;
	localparam logic [2:0] ACT_CURSOR = 3'd2;
	localparam logic [2:0] ACT_NUMBER = 3'd3;
	localparam logic [2:0] ACT_INIT   = 3'd4;

	// interface mode
	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_EIGHT = 2'd1;
	localparam logic [1:0] MODE_FOUR  = 2'd2;

	// cursor rows
	localparam logic [1:0] ROW_SECOND_BASE = 2'd0;
	localparam logic [1:0] ROW_FIRST_BASE  = 2'd1;

	// strobe byte source
	localparam logic [1:0] SRC_REQ   = 2'd0;
	localparam logic [1:0] SRC_DIGIT = 2'd1;
	localparam logic [1:0] SRC_INIT  = 2'd2;

	// part of the byte driven on the pins
	localparam logic [1:0] PART_FULL = 2'd0;
	localparam logic [1:0] PART_HI   = 2'd1;
	localparam logic [1:0] PART_LO   = 2'd2;

	localparam int BIN_W      = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int CONV_CNT_W = $clog2(BIN_W);
	localparam int BYTE_W     = 8;
	localparam int WAIT_W     = 16;
	localparam int INIT_IDX_W = 4;

	localparam logic [7:0] SET_DDRAM  = 8'b1000_0000;
	localparam logic [7:0] ROW0_BASE  = 8'h40;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] HI_MASK    = 8'b1111_0000;

	localparam int POWER_UP_WAIT_US = 40000;
	localparam int WAIT_MAX         = 65535;
	localparam logic [WAIT_W-1:0] POWER_UP_WAIT =
		WAIT_W'((POWER_UP_WAIT_US > WAIT_MAX) ? WAIT_MAX : POWER_UP_WAIT_US);
	localparam logic [WAIT_W-1:0] SHORT_WAIT = 16'd100;
	localparam logic [WAIT_W-1:0] CLEAR_WAIT = 16'd2000;

	localparam logic [INIT_IDX_W-1:0] INIT8_LAST = 4'd3;
	localparam logic [INIT_IDX_W-1:0] INIT4_LAST = 4'd8;

	typedef struct packed {
		logic       load;
		logic       conv_step;
		logic       advance;
		logic       emit;
		logic [1:0] src;
		logic [1:0] part;
		logic       last;
	} lcdws_cmd_t;

	typedef struct packed {
		logic out_free;
		logic req_byte;
		logic req_num;
		logic req_init;
		logic four_bit;
		logic conv_last;
		logic digit_skip;
		logic digits_last;
		logic init_last;
	} lcdws_status_t;

	function automatic logic [BYTE_W-1:0] init_byte(input logic four,
		input logic [INIT_IDX_W-1:0] idx);
		logic [BYTE_W-1:0] b;
		b = '0;
		if (four) begin
			unique case (idx)
				4'd0, 4'd1: b = 8'h20;
				4'd2:       b = 8'h80;
				4'd4:       b = 8'hC0;
				4'd6:       b = 8'h10;
				4'd8:       b = 8'h60;
				default:    b = 8'h00;
			endcase
		end else begin
			unique case (idx)
				4'd0:    b = 8'h38;
				4'd1:    b = 8'h0C;
				4'd2:    b = 8'h01;
				4'd3:    b = 8'h06;
				default: b = 8'h00;
			endcase
		end
		return b;
	endfunction

	function automatic logic [WAIT_W-1:0] init_wait(input logic four,
		input logic [INIT_IDX_W-1:0] idx);
		logic [WAIT_W-1:0] w;
		w = '0;
		if (four) begin
			unique case (idx)
				4'd0:       w = POWER_UP_WAIT;
				4'd3, 4'd5: w = SHORT_WAIT;
				4'd7:       w = CLEAR_WAIT;
				default:    w = '0;
			endcase
		end else begin
			unique case (idx)
				4'd0:       w = POWER_UP_WAIT;
				4'd1, 4'd2: w = SHORT_WAIT;
				4'd3:       w = CLEAR_WAIT;
				default:    w = '0;
			endcase
		end
		return w;
	endfunction

endpackage

[hdl/lcdws_ctrl.sv]
// Controller state machine: sequences requests into strobes.
`timescale 1ns / 1ps

module lcdws_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  lcdws_pkg::lcdws_status_t status,
	output lcdws_pkg::lcdws_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_CONV    = 3'd1;
	localparam logic [2:0] ST_DIGIT   = 3'd2;
	localparam logic [2:0] ST_BYTE_HI = 3'd3;
	localparam logic [2:0] ST_BYTE_LO = 3'd4;
	localparam logic [2:0] ST_INIT    = 3'd5;

	logic [2:0] state_q, state_d;
	logic [1:0] src_q, src_d;
	logic       unit_last;

	// a request byte is a single unit; a number ends with its lowest digit
	assign unit_last = (src_q == lcdws_pkg::SRC_REQ) || status.digits_last;

	always_comb begin
		state_d  = state_q;
		src_d    = src_q;
		cmd      = '0;
		cmd.src  = src_q;
		cmd.part = lcdws_pkg::PART_FULL;
		s_tready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					priority if (status.req_init) begin
						state_d = ST_INIT;
					end else if (status.req_num) begin
						state_d = ST_CONV;
						src_d   = lcdws_pkg::SRC_DIGIT;
					end else if (status.req_byte) begin
						state_d = ST_BYTE_HI;
						src_d   = lcdws_pkg::SRC_REQ;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (status.conv_last) begin
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				// drop leading zeros
				if (status.digit_skip) begin
					cmd.advance = 1'b1;
				end else begin
					state_d = ST_BYTE_HI;
				end
			end
			ST_BYTE_HI: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.four_bit) begin
						cmd.part = lcdws_pkg::PART_HI;
						state_d  = ST_BYTE_LO;
					end else begin
						cmd.last = unit_last;
						if (unit_last) begin
							state_d = ST_IDLE;
						end else begin
							cmd.advance = 1'b1;
							state_d     = ST_DIGIT;
						end
					end
				end
			end
			ST_BYTE_LO: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.part = lcdws_pkg::PART_LO;
					cmd.last = unit_last;
					if (unit_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = ST_DIGIT;
					end
				end
			end
			ST_INIT: begin
				cmd.src = lcdws_pkg::SRC_INIT;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = status.init_last;
					if (status.init_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			src_q   <= lcdws_pkg::SRC_REQ;
		end else begin
			state_q <= state_d;
			src_q   <= src_d;
		end
	end

endmodule

[hdl/lcdws_dp.sv]
// Datapath: request latch, binary to decimal converter, byte select and output register.
`timescale 1ns / 1ps

module lcdws_dp #(
	parameter int MAX_DIGITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic                            cfg_wr_data,
	input  logic [2:0]                      action,
	input  logic [lcdws_pkg::BIN_W-1:0]     value,
	input  logic [5:0]                      column,
	input  logic [1:0]                      row,
	input  lcdws_pkg::lcdws_cmd_t           cmd,
	output lcdws_pkg::lcdws_status_t        status,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            register_select,
	output logic [lcdws_pkg::BYTE_W-1:0]    bus_value,
	output logic [lcdws_pkg::WAIT_W-1:0]    wait_before_us,
	output logic                            last
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int DIG_W = 4 * MAX_DIGITS;

	logic                                four_bit_bus_q;
	logic [1:0]                          mode_q;
	logic [lcdws_pkg::BYTE_W-1:0]        byte_q;
	logic                                rs_q;
	logic [lcdws_pkg::BIN_W-1:0]         bin_q;
	logic [lcdws_pkg::BCD_W-1:0]         bcd_q, bcd_adj;
	logic [lcdws_pkg::CONV_CNT_W-1:0]    conv_cnt_q;
	logic [CNT_W-1:0]                    remain_q;
	logic                                started_q;
	logic [lcdws_pkg::INIT_IDX_W-1:0]    init_idx_q;
	logic                                out_valid_q;

	logic                                mode_active, four_mode, cursor_ok, ovf;
	logic [lcdws_pkg::BYTE_W-1:0]        cursor_byte, src_byte, pin_byte;
	logic [lcdws_pkg::WAIT_W-1:0]        src_wait;
	logic                                src_rs;
	logic [3:0]                          top_digit;

	assign mode_active = (mode_q == lcdws_pkg::MODE_EIGHT) || (mode_q == lcdws_pkg::MODE_FOUR);
	assign four_mode   = (mode_q == lcdws_pkg::MODE_FOUR);
	assign cursor_ok   = (action == lcdws_pkg::ACT_CURSOR) &&
		((row == lcdws_pkg::ROW_SECOND_BASE) || (row == lcdws_pkg::ROW_FIRST_BASE));
	assign cursor_byte = lcdws_pkg::SET_DDRAM +
		((row == lcdws_pkg::ROW_SECOND_BASE) ? lcdws_pkg::ROW0_BASE : 8'h00) +
		{2'b00, column};

	// most significant printable digit sits at a fixed nibble; digits beyond it flag overflow
	assign top_digit = bcd_q[DIG_W-1 -: 4];
	assign ovf       = (bcd_q >> DIG_W) != '0;

	always_comb begin
		status             = '0;
		status.out_free    = !out_valid_q || out_ready;
		status.req_byte    = mode_active && ((action == lcdws_pkg::ACT_DATA) ||
			(action == lcdws_pkg::ACT_CMD) || cursor_ok);
		status.req_num     = mode_active && (action == lcdws_pkg::ACT_NUMBER);
		status.req_init    = (action == lcdws_pkg::ACT_INIT);
		status.four_bit    = four_mode;
		status.conv_last   = conv_cnt_q == lcdws_pkg::CONV_CNT_W'(lcdws_pkg::BIN_W - 1);
		status.digits_last = remain_q == CNT_W'(1);
		status.digit_skip  = !started_q && (top_digit == 4'd0) && !status.digits_last && !ovf;
		status.init_last   = init_idx_q == (four_mode ? lcdws_pkg::INIT4_LAST :
			lcdws_pkg::INIT8_LAST);
	end

	// shift-and-add-3 correction on every decimal digit
	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < lcdws_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	always_comb begin
		unique case (cmd.src)
			lcdws_pkg::SRC_DIGIT: begin
				src_byte = lcdws_pkg::ASCII_ZERO + {4'b0000, top_digit};
				src_wait = '0;
				src_rs   = 1'b1;
			end
			lcdws_pkg::SRC_INIT: begin
				src_byte = lcdws_pkg::init_byte(four_mode, init_idx_q);
				src_wait = lcdws_pkg::init_wait(four_mode, init_idx_q);
				src_rs   = 1'b0;
			end
			default: begin
				src_byte = byte_q;
				src_wait = '0;
				src_rs   = rs_q;
			end
		endcase
		unique case (cmd.part)
			lcdws_pkg::PART_HI: pin_byte = src_byte & lcdws_pkg::HI_MASK;
			lcdws_pkg::PART_LO: pin_byte = {src_byte[3:0], 4'b0000};
			default:            pin_byte = src_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_bit_bus_q <= 1'b0;
			mode_q         <= lcdws_pkg::MODE_NONE;
			conv_cnt_q     <= '0;
			remain_q       <= '0;
			started_q      <= 1'b0;
			init_idx_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				four_bit_bus_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				conv_cnt_q <= '0;
				remain_q   <= CNT_W'(MAX_DIGITS);
				started_q  <= 1'b0;
				init_idx_q <= '0;
				if (status.req_init) begin
					mode_q <= four_bit_bus_q ? lcdws_pkg::MODE_FOUR : lcdws_pkg::MODE_EIGHT;
				end
			end else begin
				if (cmd.conv_step) begin
					conv_cnt_q <= conv_cnt_q + 1'b1;
				end
				if (cmd.advance) begin
					remain_q <= remain_q - 1'b1;
				end
				if (cmd.emit && (cmd.src == lcdws_pkg::SRC_DIGIT)) begin
					started_q <= 1'b1;
				end
				if (cmd.emit && (cmd.src == lcdws_pkg::SRC_INIT)) begin
					init_idx_q <= init_idx_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= (action == lcdws_pkg::ACT_CURSOR) ? cursor_byte : value[7:0];
			rs_q   <= (action == lcdws_pkg::ACT_DATA);
			bin_q  <= value;
			bcd_q  <= '0;
		end else if (cmd.conv_step) begin
			bcd_q <= {bcd_adj[lcdws_pkg::BCD_W-2:0], bin_q[lcdws_pkg::BIN_W-1]};
			bin_q <= {bin_q[lcdws_pkg::BIN_W-2:0], 1'b0};
		end else if (cmd.advance) begin
			bcd_q <= {bcd_q[lcdws_pkg::BCD_W-5:0], 4'b0000};
		end
		if (cmd.emit) begin
			register_select <= src_rs;
			bus_value       <= pin_byte;
			wait_before_us  <= src_wait;
			last            <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hdl/char_lcd_write_sequencer.sv]
// Top level of the character LCD write sequencer.
// Slave stream s_*: one request per handshake; s_tuser is the action code, s_tdata
// carries value, column and row. Master stream m_*: one enable strobe per
// handshake with register select on m_tuser, pin byte and wait on m_tdata and
// the final strobe of a request flagged on m_tlast. cfg_wr_en/cfg_wr_data set
// the bus width that the next init request selects; write it only while idle.
// A byte, command or cursor request goes from acceptance to ST_BYTE_HI, which
// registers its first strobe in the output register, then gives one strobe per
// cycle while the receiver does not stall. A number first runs through
// shift-and-add conversion, then a digit check before each digit drops leading
// zeros; each digit then passes ST_DIGIT and ST_BYTE_HI, plus ST_BYTE_LO on a
// 4-bit bus. Init gives 4 or 9 strobes, one per cycle while the receiver does
// not stall. A request occupies the block from acceptance until its last strobe
// is in the output register. A stalled receiver holds the output register and
// stops the sequencer at its next strobe.
// Reset clears the bus width, drops back to no initialised interface and
// empties the output register; requests other than init then give no strobes.
`timescale 1ns / 1ps
`include "char_lcd_write_sequencer_assert.svh"

module char_lcd_write_sequencer #(
	parameter int MAX_DIGITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value[31:0], column[37:32], row[39:38]
	input  logic [2:0]  s_tuser,   // action[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // bus_value[7:0], wait_before_us[23:8]
	output logic        m_tuser,   // register_select[0]
	output logic        m_tlast
);

	lcdws_pkg::lcdws_cmd_t        cmd;
	lcdws_pkg::lcdws_status_t     status;
	logic [lcdws_pkg::BYTE_W-1:0] bus_value;
	logic [lcdws_pkg::WAIT_W-1:0] wait_before_us;

	lcdws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lcdws_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.action          (s_tuser),
		.value           (s_tdata[31:0]),
		.column          (s_tdata[37:32]),
		.row             (s_tdata[39:38]),
		.cmd             (cmd),
		.status          (status),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.register_select (m_tuser),
		.bus_value       (bus_value),
		.wait_before_us  (wait_before_us),
		.last            (m_tlast)
	);

	assign m_tdata = {wait_before_us, bus_value};

	`LCDWS_ASSERT_NOW(a_emit_into_free, cmd.emit, status.out_free, "strobe overwrote a held result")
	`LCDWS_ASSERT_NOW(a_emit_while_busy, cmd.emit, !s_tready, "strobe issued while idle")
	`LCDWS_ASSERT_NEXT(a_init_busy, s_tvalid && s_tready && (s_tuser == lcdws_pkg::ACT_INIT), !s_tready, "init request did not occupy the block")

endmodule

[test/tb_top.sv]
// Self-checking testbench for the character LCD write sequencer.
`timescale 1ns / 1ps

module tb_top;

	localparam int          CLK_HALF_NS   = 4;
	localparam int          RESET_CYCLES  = 11;
	localparam int          SETTLE_CYCLES = 80;
	localparam int          CYCLE_LIMIT   = 200000;
	localparam int          IDLE_PERCENT  = 6;
	localparam int          ITEMS_PER_SET = 19;
	localparam int          DIGIT_LIMIT   = 10;
	localparam int unsigned POWER_UP_US   = 40000;
	localparam int unsigned SHORT_US      = 100;
	localparam int unsigned CLEAR_US      = 2000;
	localparam int unsigned WAIT_CEIL     = 65535;
	localparam logic [2:0]  ACT_RSVD_LO   = 3'd5;
	localparam logic [2:0]  ACT_RSVD_HI   = 3'd7;
	localparam logic [1:0]  ROW_THIRD     = 2'd2;
	localparam logic [1:0]  ROW_FOURTH    = 2'd3;
	localparam logic        RS_INSTR      = 1'b0;
	localparam logic        RS_DATA       = 1'b1;

	typedef struct {
		logic        rs;
		logic [7:0]  bus;
		logic [15:0] wait_us;
		logic        last;
	} strobe_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	strobe_t     expected_strobes[$];
	logic        four_bit_sel = 1'b0;
	logic [1:0]  lcd_mode = lcdws_pkg::MODE_NONE;
	bit          no_idle = 1'b0;
	int          fail_count = 0;
	int          cycle_count = 0;

	char_lcd_write_sequencer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	initial clk = 1'b0;
	always #(CLK_HALF_NS) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: stall at random unless a quiet stretch is running.
	always @(negedge clk) begin
		m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	function automatic void push_strobe(input logic rs, input logic [7:0] bus,
		input int unsigned wait_us);
		strobe_t s;
		s.rs      = rs;
		s.bus     = bus;
		s.wait_us = (wait_us > WAIT_CEIL) ? 16'(WAIT_CEIL) : 16'(wait_us);
		s.last    = 1'b0;
		expected_strobes.push_back(s);
	endfunction

	function automatic void push_byte(input logic rs, input logic [7:0] b);
		if (lcd_mode == lcdws_pkg::MODE_EIGHT) begin
			push_strobe(rs, b, 0);
		end else if (lcd_mode == lcdws_pkg::MODE_FOUR) begin
			// Both nibbles go out on the upper pins, lower pins held at zero.
			push_strobe(rs, {b[7:4], 4'h0}, 0);
			push_strobe(rs, {b[3:0], 4'h0}, 0);
		end
	endfunction

	function automatic void predict_strobes(input logic [2:0] action,
		input logic [31:0] value, input logic [5:0] column, input logic [1:0] row);
		int          start_size;
		int          k;
		int          i;
		logic [31:0] v;
		logic [3:0]  digits[DIGIT_LIMIT];
		start_size = expected_strobes.size();
		unique case (action)
			lcdws_pkg::ACT_DATA: push_byte(RS_DATA, value[7:0]);
			lcdws_pkg::ACT_CMD: push_byte(RS_INSTR, value[7:0]);
			lcdws_pkg::ACT_CURSOR: begin
				if (row == lcdws_pkg::ROW_SECOND_BASE)
					push_byte(RS_INSTR, lcdws_pkg::SET_DDRAM + lcdws_pkg::ROW0_BASE +
						8'(column));
				else if (row == lcdws_pkg::ROW_FIRST_BASE)
					push_byte(RS_INSTR, lcdws_pkg::SET_DDRAM + 8'(column));
			end
			lcdws_pkg::ACT_NUMBER: begin
				k = 0;
				v = value;
				do begin
					digits[k] = 4'(v % 10);
					k++;
					v = v / 10;
				end while (v != 0 && k < DIGIT_LIMIT);
				for (i = k - 1; i >= 0; i--)
					push_byte(RS_DATA, lcdws_pkg::ASCII_ZERO + 8'(digits[i]));
			end
			lcdws_pkg::ACT_INIT: begin
				if (four_bit_sel) begin
					push_strobe(RS_INSTR, 8'h20, POWER_UP_US);
					push_strobe(RS_INSTR, 8'h20, 0);
					push_strobe(RS_INSTR, 8'h80, 0);
					push_strobe(RS_INSTR, 8'h00, SHORT_US);
					push_strobe(RS_INSTR, 8'hC0, 0);
					push_strobe(RS_INSTR, 8'h00, SHORT_US);
					push_strobe(RS_INSTR, 8'h10, 0);
					push_strobe(RS_INSTR, 8'h00, CLEAR_US);
					push_strobe(RS_INSTR, 8'h60, 0);
					lcd_mode = lcdws_pkg::MODE_FOUR;
				end else begin
					push_strobe(RS_INSTR, 8'h38, POWER_UP_US);
					push_strobe(RS_INSTR, 8'h0C, SHORT_US);
					push_strobe(RS_INSTR, 8'h01, SHORT_US);
					push_strobe(RS_INSTR, 8'h06, CLEAR_US);
					lcd_mode = lcdws_pkg::MODE_EIGHT;
				end
			end
			default: ;
		endcase
		if (expected_strobes.size() > start_size)
			expected_strobes[expected_strobes.size() - 1].last = 1'b1;
	endfunction

	task automatic send_request(input logic [2:0] action, input logic [31:0] value,
		input logic [5:0] column, input logic [1:0] row);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= action;
		s_tdata  <= {row, column, value};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_strobes(action, value, column, row);
	endtask

	task automatic drop_request();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Hold until every strobe is in, then let a slow conversion run out.
	task automatic wait_idle();
		while (expected_strobes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_bus_width(input logic four);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= four;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		four_bit_sel = four;
	endtask

	task automatic check_field(input string what, input int unsigned exp_v,
		input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : strobe_checker
		strobe_t exp_s;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_strobes.size() == 0) begin
				$display("%0t: unexpected strobe, expected none actual %0h/%0h/%0h",
					$time, m_tuser, m_tdata, m_tlast);
				fail_count++;
			end else begin
				exp_s = expected_strobes.pop_front();
				check_field("register_select", exp_s.rs, m_tuser);
				check_field("bus_value", exp_s.bus, m_tdata[7:0]);
				check_field("wait_before_us", exp_s.wait_us, m_tdata[23:8]);
				check_field("last", exp_s.last, m_tlast);
			end
		end
	end

	task automatic test_before_init();
		send_request(lcdws_pkg::ACT_DATA, 32'hFFFF_FFFF, 6'd63, ROW_FOURTH);
		send_request(lcdws_pkg::ACT_CMD, 32'h0000_0001, 6'd0, lcdws_pkg::ROW_SECOND_BASE);
		send_request(lcdws_pkg::ACT_CURSOR, 32'd0, 6'd5, lcdws_pkg::ROW_SECOND_BASE);
		send_request(lcdws_pkg::ACT_NUMBER, 32'd123, 6'd0, lcdws_pkg::ROW_FIRST_BASE);
		send_request(ACT_RSVD_LO, 32'hA5A5_A5A5, 6'd21, ROW_THIRD);
		drop_request();
		wait_idle();
	endtask

	task automatic test_init_eight();
		write_bus_width(1'b0);
		send_request(lcdws_pkg::ACT_INIT, 32'd0, 6'd0, lcdws_pkg::ROW_SECOND_BASE);
		send_request(lcdws_pkg::ACT_DATA, 32'hFFFF_FF00, 6'd0, lcdws_pkg::ROW_SECOND_BASE);
		send_request(lcdws_pkg::ACT_DATA, 32'h0000_00FF, 6'd63, ROW_FOURTH);
		send_request(lcdws_pkg::ACT_CMD, 32'h1234_5601, 6'd42, ROW_THIRD);
		send_request(lcdws_pkg::ACT_CURSOR, 32'd0, 6'd63, lcdws_pkg::ROW_SECOND_BASE);
		send_request(lcdws_pkg::ACT_CURSOR, 32'd0, 6'd0, lcdws_pkg::ROW_FIRST_BASE);
		send_request(lcdws_pkg::ACT_CURSOR, 32'd0, 6'd10, ROW_THIRD);
		send_request(lcdws_pkg::ACT_CURSOR, 32'd0, 6'd63, ROW_FOURTH);
		send_request(lcdws_pkg::ACT_NUMBER, 32'd0, 6'd0, lcdws_pkg::ROW_SECOND_BASE);
		send_request(lcdws_pkg::ACT_NUMBER, 32'hFFFF_FFFF, 6'd0, lcdws_pkg::ROW_SECOND_BASE);
		send_request(lcdws_pkg::ACT_NUMBER, 32'd1_000_000_007, 6'd0,
			lcdws_pkg::ROW_SECOND_BASE);
		send_request(ACT_RSVD_HI, 32'hFFFF_FFFF, 6'd63, ROW_FOURTH);
		drop_request();
		wait_idle();
	endtask

	task automatic test_init_four();
		write_bus_width(1'b1);
		send_request(lcdws_pkg::ACT_INIT, 32'hFFFF_FFFF, 6'd63, ROW_FOURTH);
		send_request(lcdws_pkg::ACT_DATA, 32'h0000_00A5, 6'd0, lcdws_pkg::ROW_SECOND_BASE);
		send_request(lcdws_pkg::ACT_CMD, 32'h0000_005A, 6'd0, lcdws_pkg::ROW_SECOND_BASE);
		send_request(lcdws_pkg::ACT_CURSOR, 32'd0, 6'd63, lcdws_pkg::ROW_FIRST_BASE);
		send_request(lcdws_pkg::ACT_CURSOR, 32'd0, 6'd33, lcdws_pkg::ROW_SECOND_BASE);
		send_request(lcdws_pkg::ACT_NUMBER, 32'hFFFF_FFFF, 6'd0, lcdws_pkg::ROW_SECOND_BASE);
		send_request(lcdws_pkg::ACT_NUMBER, 32'd0, 6'd0, lcdws_pkg::ROW_SECOND_BASE);
		drop_request();
		wait_idle();
	endtask

	task automatic test_random();
		int          set_idx;
		int          n;
		int          pick;
		logic [2:0]  action;
		logic [31:0] value;
		logic        width;
		width = 1'($urandom_range(0, 1));
		for (set_idx = 0; set_idx < 4; set_idx++) begin
			// Alternate the bus width so both settings get random traffic.
			width   = ~width;
			no_idle = (set_idx == 2);
			write_bus_width(width);
			send_request(lcdws_pkg::ACT_INIT, $urandom, 6'($urandom), 2'($urandom));
			for (n = 0; n < ITEMS_PER_SET; n++) begin
				pick  = $urandom_range(0, 99);
				value = $urandom;
				if (pick < 30)
					action = lcdws_pkg::ACT_DATA;
				else if (pick < 48)
					action = lcdws_pkg::ACT_CMD;
				else if (pick < 65)
					action = lcdws_pkg::ACT_CURSOR;
				else if (pick < 88)
					action = lcdws_pkg::ACT_NUMBER;
				else if (pick < 94)
					action = lcdws_pkg::ACT_INIT;
				else
					action = 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
				// Spread numbers over every digit count.
				if (action == lcdws_pkg::ACT_NUMBER && $urandom_range(0, 1))
					value = value >> $urandom_range(0, 31);
				send_request(action, value, 6'($urandom), 2'($urandom));
			end
			drop_request();
			wait_idle();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = lcdws_pkg::ACT_DATA;
		m_tready    = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_before_init();
		test_init_eight();
		test_init_four();
		test_random();
		wait_idle();
		if (fail_count == 0 && expected_strobes.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/lcdws_pkg.sv
hdl/lcdws_ctrl.sv
hdl/lcdws_dp.sv
hdl/char_lcd_write_sequencer.sv
test/tb_top.sv
